// File: design/ps2h_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ps2h_pkg
// Shared types, codes and translation tables for the scan-to-report converter.
// -----------------------------------------------------------------------------
package ps2h_pkg;

  localparam int unsigned KEY_AW      = 9;
  localparam int unsigned SLOT_COUNT  = 6;
  localparam int unsigned BASE_ROM_SZ = 132;

  localparam logic       KIND_SCAN = 1'b0;
  localparam logic       KIND_POLL = 1'b1;

  localparam logic [7:0] BYTE_EXT   = 8'hE0;
  localparam logic [7:0] BYTE_REL   = 8'hF0;
  localparam logic [7:0] BYTE_FAKE  = 8'h12;
  localparam logic [7:0] BYTE_PAUSE = 8'h77;

  localparam logic [KEY_AW-1:0] KEY_LCTRL  = 9'h014;
  localparam logic [KEY_AW-1:0] KEY_LSHIFT = 9'h012;
  localparam logic [KEY_AW-1:0] KEY_LALT   = 9'h011;
  localparam logic [KEY_AW-1:0] KEY_LGUI   = 9'h11F;
  localparam logic [KEY_AW-1:0] KEY_RCTRL  = 9'h114;
  localparam logic [KEY_AW-1:0] KEY_RSHIFT = 9'h059;
  localparam logic [KEY_AW-1:0] KEY_RALT   = 9'h111;
  localparam logic [KEY_AW-1:0] KEY_RGUI   = 9'h127;

  localparam logic [7:0] BASE_ROM [0:BASE_ROM_SZ-1] = '{
    8'h00,8'h42,8'h00,8'h3E, 8'h3C,8'h3A,8'h3B,8'h45, 8'h00,8'h43,8'h41,8'h3F,
    8'h3D,8'h2B,8'h35,8'h00, 8'h00,8'h00,8'h00,8'h00, 8'h48,8'h14,8'h1E,8'h00,
    8'h00,8'h00,8'h1D,8'h16, 8'h04,8'h1A,8'h1F,8'h00, 8'h00,8'h06,8'h1B,8'h07,
    8'h08,8'h21,8'h20,8'h00, 8'h00,8'h2C,8'h19,8'h09, 8'h17,8'h15,8'h22,8'h00,
    8'h00,8'h11,8'h05,8'h0B, 8'h0A,8'h1C,8'h23,8'h00, 8'h00,8'h00,8'h10,8'h0D,
    8'h18,8'h24,8'h25,8'h00, 8'h00,8'h36,8'h0E,8'h0C, 8'h12,8'h27,8'h26,8'h00,
    8'h00,8'h37,8'h38,8'h0F, 8'h33,8'h13,8'h2D,8'h00, 8'h00,8'h00,8'h34,8'h00,
    8'h2F,8'h2E,8'h00,8'h00, 8'h39,8'h00,8'h28,8'h30, 8'h00,8'h32,8'h00,8'h00,
    8'h00,8'h64,8'h00,8'h00, 8'h00,8'h00,8'h2A,8'h00, 8'h00,8'h59,8'h00,8'h5C,
    8'h5F,8'h00,8'h00,8'h00, 8'h62,8'h63,8'h5A,8'h5D, 8'h5E,8'h60,8'h29,8'h53,
    8'h44,8'h57,8'h5B,8'h56, 8'h55,8'h61,8'h47,8'h00, 8'h00,8'h00,8'h00,8'h40
  };

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic clear_step;
    logic set_ext;
    logic set_rel;
    logic clr_pend;
    logic set_changed;
    logic clr_changed;
    logic rd_lctrl;
    logic key_write;
    logic report_init;
    logic scan_step;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_accept;
    logic kind;
    logic is_ext;
    logic is_rel;
    logic fake_shift;
    logic pause_hit;
    logic changed;
    logic cnt_last;
    logic out_busy;
  } dp_status_t;

  function automatic logic [7:0] translate(input logic [KEY_AW-1:0] key);
    logic [7:0] code;
    code = 8'h00;
    if (!key[KEY_AW-1]) begin
      if (key[7:0] < 8'(BASE_ROM_SZ)) code = BASE_ROM[key[7:0]];
    end else begin
      unique case (key[7:0])
        8'h4A:   code = 8'h54;
        8'h5A:   code = 8'h58;
        8'h69:   code = 8'h4D;
        8'h6B:   code = 8'h50;
        8'h6C:   code = 8'h4A;
        8'h70:   code = 8'h49;
        8'h71:   code = 8'h4C;
        8'h72:   code = 8'h51;
        8'h74:   code = 8'h4F;
        8'h75:   code = 8'h52;
        8'h7A:   code = 8'h4E;
        8'h7C:   code = 8'h46;
        8'h7D:   code = 8'h4B;
        default: code = 8'h00;
      endcase
    end
    return code;
  endfunction

  function automatic logic [7:0] mod_mask(input logic [KEY_AW-1:0] key);
    logic [7:0] m;
    m = 8'h00;
    m[0] = (key == KEY_LCTRL);
    m[1] = (key == KEY_LSHIFT);
    m[2] = (key == KEY_LALT);
    m[3] = (key == KEY_LGUI);
    m[4] = (key == KEY_RCTRL);
    m[5] = (key == KEY_RSHIFT);
    m[6] = (key == KEY_RALT);
    m[7] = (key == KEY_RGUI);
    return m;
  endfunction

endpackage

// File: design/ps2h_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ps2h_in_if / ps2h_out_if
// Valid/ready channels for scan events and HID reports.
// -----------------------------------------------------------------------------
interface ps2h_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] scan_byte;
  modport source (output valid, kind, scan_byte, input ready);
  modport sink   (input valid, kind, scan_byte, output ready);
endinterface

interface ps2h_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifiers;
  logic [7:0] key_slot_0;
  logic [7:0] key_slot_1;
  logic [7:0] key_slot_2;
  logic [7:0] key_slot_3;
  logic [7:0] key_slot_4;
  logic [7:0] key_slot_5;
  modport source (output valid, modifiers, key_slot_0, key_slot_1, key_slot_2,
                  key_slot_3, key_slot_4, key_slot_5, input ready);
  modport sink   (input valid, modifiers, key_slot_0, key_slot_1, key_slot_2,
                  key_slot_3, key_slot_4, key_slot_5, output ready);
endinterface

// File: design/ps2h_ram.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ps2h_ram
// Generic single-port RAM with registered read.
// -----------------------------------------------------------------------------
module ps2h_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: design/ps2h_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ps2h_ctrl
// Sequencer: map clear, byte decode, map update, report scan and emit.
// -----------------------------------------------------------------------------
module ps2h_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  ps2h_pkg::dp_status_t st,
  output ps2h_pkg::ctl_cmd_t   cmd
);
  import ps2h_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (st.cnt_last) state_next = ST_IDLE;
      ST_IDLE:   if (st.in_accept) state_next = ST_DECODE;
      ST_DECODE: begin
        priority if (st.kind == KIND_POLL) state_next = st.changed ? ST_SCAN : ST_IDLE;
        else if (st.is_ext || st.is_rel || st.fake_shift) state_next = ST_IDLE;
        else state_next = ST_CHECK;
      end
      ST_CHECK:  state_next = ST_IDLE;
      ST_SCAN:   if (st.cnt_last) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_EMIT;
      ST_EMIT:   if (!st.out_busy) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_CLEAR:  cmd.clear_step = 1'b1;
      ST_IDLE:   cmd.in_ready = 1'b1;
      ST_DECODE: begin
        priority if (st.kind == KIND_POLL) begin
          cmd.clr_changed = st.changed;
          cmd.report_init = st.changed;
        end else if (st.is_ext) begin
          cmd.set_ext = 1'b1;
        end else if (st.is_rel) begin
          cmd.set_rel = 1'b1;
        end else if (st.fake_shift) begin
          cmd.clr_pend = 1'b1;
        end else begin
          cmd.rd_lctrl = 1'b1;
        end
      end
      ST_CHECK: begin
        cmd.clr_pend    = 1'b1;
        cmd.key_write   = !st.pause_hit;
        cmd.set_changed = !st.pause_hit;
      end
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_DRAIN:  cmd = '0;
      ST_EMIT:   cmd.emit = !st.out_busy;
      default:   cmd = '0;
    endcase
  end
endmodule

// File: design/ps2h_datapath.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ps2h_datapath
// Key-down map RAM, prefix flags, scan accumulator and report register.
// -----------------------------------------------------------------------------
module ps2h_datapath #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  ps2h_in_if.sink              scan_in,
  ps2h_out_if.source           report_out,
  input  ps2h_pkg::ctl_cmd_t   cmd,
  output ps2h_pkg::dp_status_t st
);
  import ps2h_pkg::*;

  logic              kind;
  logic [7:0]        byte_q;
  logic              ext_pend, rel_pend, changed;
  logic [KEY_AW-1:0] cnt;
  logic              rd_valid;
  logic [KEY_AW-1:0] rd_key;
  logic [7:0]        mods;
  logic [7:0]        slots [0:SLOT_COUNT-1];
  logic [2:0]        slot_cnt;
  logic              out_valid;

  logic              ram_we, ram_wdata, ram_rdata;
  logic [KEY_AW-1:0] ram_addr;
  logic [7:0]        code;

  assign scan_in.ready = cmd.in_ready;

  always_ff @(posedge clk) begin
    if (scan_in.valid && cmd.in_ready) begin
      kind   <= scan_in.kind;
      byte_q <= scan_in.scan_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_pend <= 1'b0;
      rel_pend <= 1'b0;
      changed  <= 1'b0;
      cnt      <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.set_ext) ext_pend <= 1'b1;
      if (cmd.set_rel) rel_pend <= 1'b1;
      if (cmd.clr_pend) begin
        ext_pend <= 1'b0;
        rel_pend <= 1'b0;
      end
      if (cmd.set_changed) changed <= 1'b1;
      if (cmd.clr_changed) changed <= 1'b0;
      if (cmd.clear_step || cmd.scan_step) cnt <= cnt + 1'b1;
      rd_valid <= cmd.scan_step;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    ram_addr  = cnt;
    priority if (cmd.clear_step) begin
      ram_we = 1'b1;
    end else if (cmd.key_write) begin
      ram_we    = 1'b1;
      ram_wdata = !rel_pend;
      ram_addr  = {ext_pend, byte_q};
    end else if (cmd.rd_lctrl) begin
      ram_addr = KEY_LCTRL;
    end else begin
      ram_addr = cnt;
    end
  end

  ps2h_ram #(.WIDTH(1), .DEPTH(2**KEY_AW)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    rd_key <= cnt;
  end

  assign code = translate(rd_key);

  always_ff @(posedge clk) begin
    if (cmd.report_init) begin
      mods     <= '0;
      slot_cnt <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) slots[i] <= '0;
    end else if (rd_valid && ram_rdata) begin
      mods <= mods | mod_mask(rd_key);
      if (code != 8'h00 && slot_cnt < 3'(KEY_SLOTS)) begin
        slots[slot_cnt] <= code;
        slot_cnt        <= slot_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (report_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      report_out.modifiers  <= mods;
      report_out.key_slot_0 <= slots[0];
      report_out.key_slot_1 <= slots[1];
      report_out.key_slot_2 <= slots[2];
      report_out.key_slot_3 <= slots[3];
      report_out.key_slot_4 <= slots[4];
      report_out.key_slot_5 <= slots[5];
    end
  end

  assign report_out.valid = out_valid;

  assign st.in_accept  = scan_in.valid && cmd.in_ready;
  assign st.kind       = kind;
  assign st.is_ext     = (byte_q == BYTE_EXT);
  assign st.is_rel     = (byte_q == BYTE_REL);
  assign st.fake_shift = ext_pend && (byte_q == BYTE_FAKE);
  assign st.pause_hit  = !ext_pend && (byte_q == BYTE_PAUSE) && ram_rdata;
  assign st.changed    = changed;
  assign st.cnt_last   = (cnt == '1);
  assign st.out_busy   = out_valid && !report_out.ready;
endmodule

// File: design/ps2_scan_to_hid_report.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ps2_scan_to_hid_report
// PS/2 set-2 scan bytes and host polls in, HID boot keyboard reports out.
// -----------------------------------------------------------------------------
//  channel     dir  transaction
//  scan_in     in   kind + scan_byte (scan byte or host poll)
//  report_out  out  modifiers + key_slot_0..5
//
//  Key byte: accept, decode (map read of left ctrl), then check and map write;
//  prefix byte or extended 0x12: accept, decode.
//  Poll with changes: accept, decode, 512-entry map scan, drain, emit; one
//  key per cycle through the single map RAM port; idle poll: accept, decode.
//  After reset, a pass clears all 512 map entries; scan_in.ready stays low.
//  A report waits in the output register; a stalled report holds the next
//  poll in the emit step only.
// -----------------------------------------------------------------------------
module ps2_scan_to_hid_report #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input logic         clk,
  input logic         rst,
  ps2h_in_if.sink     scan_in,
  ps2h_out_if.source  report_out
);
  import ps2h_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t st;

  ps2h_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  ps2h_datapath #(.KEY_SLOTS(KEY_SLOTS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .scan_in    (scan_in),
    .report_out (report_out),
    .cmd        (cmd),
    .st         (st)
  );
endmodule

// File: design/ps2h_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ps2h_checker
// Port-level checks on the converter, bound to the top level.
// -----------------------------------------------------------------------------
module ps2h_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] modifiers,
  input logic [7:0] key_slot_0,
  input logic [7:0] key_slot_1
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("report dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(modifiers))
    else $error("report changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken during work");

  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("report emitted from idle");

  a_slots_packed: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_slot_0 == 8'h00 |-> key_slot_1 == 8'h00)
    else $error("key slots not packed");
endmodule

bind ps2_scan_to_hid_report ps2h_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (scan_in.valid),
  .in_ready   (scan_in.ready),
  .out_valid  (report_out.valid),
  .out_ready  (report_out.ready),
  .modifiers  (report_out.modifiers),
  .key_slot_0 (report_out.key_slot_0),
  .key_slot_1 (report_out.key_slot_1)
);

// File: sim/ps2_scan_to_hid_report_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ps2_scan_to_hid_report_tb
// Sends scan bytes and host polls to the converter and keeps its own key map
// to predict every report. Each report is compared as a whole, in order,
// against the oldest prediction. Includes directed cases, random typing
// sequences, noise bytes, random gaps on both sides and a long receiver stall.
// -----------------------------------------------------------------------------
module ps2_scan_to_hid_report_tb;
  import ps2h_pkg::*;

  typedef struct packed {
    logic [7:0] modifiers;
    logic [7:0] s0, s1, s2, s3, s4, s5;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ps2h_in_if  scan_in ();
  ps2h_out_if report_out ();

  ps2_scan_to_hid_report DUT (
    .clk        (clk),
    .rst        (rst),
    .scan_in    (scan_in.sink),
    .report_out (report_out.source)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [511:0] keys_down;
  logic         ext_pend, rel_pend, changed;

  report_t reports_due[$];
  int      mismatches = 0;
  int      reports_seen = 0;
  int      items_sent = 0;
  int      stall_cycles = 0;
  logic    stall_go = 1'b0;
  logic    quiet_sink = 1'b0;

  function automatic logic [7:0] hid_code(input logic [8:0] key);
    logic [7:0] code;
    code = 8'h00;
    if (!key[8]) begin
      if (key[7:0] < 8'(BASE_ROM_SZ)) code = BASE_ROM[key[7:0]];
    end else begin
      case (key[7:0])
        8'h4A: code = 8'h54;
        8'h5A: code = 8'h58;
        8'h69: code = 8'h4D;
        8'h6B: code = 8'h50;
        8'h6C: code = 8'h4A;
        8'h70: code = 8'h49;
        8'h71: code = 8'h4C;
        8'h72: code = 8'h51;
        8'h74: code = 8'h4F;
        8'h75: code = 8'h52;
        8'h7A: code = 8'h4E;
        8'h7C: code = 8'h46;
        8'h7D: code = 8'h4B;
        default: code = 8'h00;
      endcase
    end
    return code;
  endfunction

  task automatic track_event(input logic kind, input logic [7:0] b);
    report_t r;
    logic [7:0] slots [0:5];
    logic [7:0] code;
    int n;
    if (kind == KIND_SCAN) begin
      if (b == BYTE_EXT) ext_pend = 1'b1;
      else if (b == BYTE_REL) rel_pend = 1'b1;
      else if (ext_pend && b == BYTE_FAKE) begin
        ext_pend = 1'b0; rel_pend = 1'b0;
      end else if (!ext_pend && b == BYTE_PAUSE && keys_down[KEY_LCTRL]) begin
        rel_pend = 1'b0;
      end else begin
        keys_down[{ext_pend, b}] = !rel_pend;
        changed = 1'b1;
        ext_pend = 1'b0; rel_pend = 1'b0;
      end
    end else if (changed) begin
      changed = 1'b0;
      n = 0;
      for (int i = 0; i < 6; i++) slots[i] = 8'h00;
      for (int k = 0; k < 512 && n < 6; k++) begin
        code = hid_code(9'(k));
        if (keys_down[k] && code != 8'h00) begin
          slots[n] = code;
          n++;
        end
      end
      r.modifiers = {keys_down[KEY_RGUI], keys_down[KEY_RALT], keys_down[KEY_RSHIFT],
                     keys_down[KEY_RCTRL], keys_down[KEY_LGUI], keys_down[KEY_LALT],
                     keys_down[KEY_LSHIFT], keys_down[KEY_LCTRL]};
      {r.s0, r.s1, r.s2, r.s3, r.s4, r.s5} =
        {slots[0], slots[1], slots[2], slots[3], slots[4], slots[5]};
      reports_due.push_back(r);
    end
  endtask

  task automatic random_gap();
    int g;
    g = $urandom_range(0, 99);
    if (g < 60) g = 0;
    else if (g < 95) g = $urandom_range(1, 4);
    else g = $urandom_range(10, 60);
    repeat (g) @(posedge clk);
  endtask

  task automatic send_item(input logic kind, input logic [7:0] b, input bit gaps = 1);
    scan_in.valid     <= 1'b1;
    scan_in.kind      <= kind;
    scan_in.scan_byte <= b;
    @(posedge clk);
    while (!scan_in.ready) @(posedge clk);
    track_event(kind, b);
    items_sent++;
    scan_in.valid <= 1'b0;
    @(posedge clk);
    if (gaps) random_gap();
  endtask

  task automatic wait_drained();
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  // sink: random backpressure, a forced stall window and an always-ready quiet mode
  always @(posedge clk) begin
    if (rst) report_out.ready <= 1'b0;
    else if (stall_go && stall_cycles < 3000) begin
      report_out.ready <= 1'b0;
      stall_cycles <= stall_cycles + 1;
    end else if (quiet_sink) report_out.ready <= 1'b1;
    else report_out.ready <= ($urandom_range(0, 99) < 70);
  end

  always @(posedge clk) begin
    report_t got, want;
    if (!rst && report_out.valid && report_out.ready) begin
      got = {report_out.modifiers, report_out.key_slot_0, report_out.key_slot_1,
             report_out.key_slot_2, report_out.key_slot_3, report_out.key_slot_4,
             report_out.key_slot_5};
      reports_seen++;
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report %h", got);
      end else begin
        want = reports_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("report mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  task automatic test_directed();
    send_item(KIND_POLL, 8'h00);           // idle poll
    send_item(KIND_SCAN, 8'h1C);
    send_item(KIND_POLL, 8'h00);
    send_item(KIND_POLL, 8'hFF);           // nothing changed
    send_item(KIND_SCAN, 8'h1C);           // repeated press
    send_item(KIND_POLL, 8'h00);
    send_item(KIND_SCAN, 8'h14); send_item(KIND_SCAN, 8'h12);
    send_item(KIND_SCAN, 8'h11); send_item(KIND_SCAN, 8'h59);
    send_item(KIND_SCAN, BYTE_EXT); send_item(KIND_SCAN, 8'h1F);
    send_item(KIND_SCAN, BYTE_EXT); send_item(KIND_SCAN, 8'h14);
    send_item(KIND_SCAN, BYTE_EXT); send_item(KIND_SCAN, 8'h11);
    send_item(KIND_SCAN, BYTE_EXT); send_item(KIND_SCAN, 8'h27);
    send_item(KIND_SCAN, BYTE_EXT); send_item(KIND_SCAN, BYTE_FAKE);  // fake shift
    send_item(KIND_SCAN, BYTE_PAUSE);      // ignored while lctrl held
    send_item(KIND_SCAN, 8'hE1);           // untranslated
    send_item(KIND_SCAN, 8'hFF);
    send_item(KIND_POLL, 8'h00);
    wait_drained();
  endtask

  task automatic test_release_and_overflow();
    for (int k = 1; k < 132; k += 9) send_item(KIND_SCAN, 8'(k));
    send_item(KIND_SCAN, BYTE_EXT); send_item(KIND_SCAN, 8'h7D);
    send_item(KIND_POLL, 8'h00);
    for (int k = 1; k < 132; k += 9) begin
      send_item(KIND_SCAN, BYTE_REL, 0);
      send_item(KIND_SCAN, 8'(k), 0);
    end
    send_item(KIND_SCAN, BYTE_EXT, 0);
    send_item(KIND_SCAN, BYTE_REL, 0);
    send_item(KIND_SCAN, 8'h7D, 0);
    send_item(KIND_SCAN, BYTE_PAUSE);      // pause key while lctrl is still held
    send_item(KIND_POLL, 8'h00);
    wait_drained();
  endtask

  task automatic test_random_typing();
    int sel;
    logic [7:0] b;
    for (int n = 0; n < 750; n++) begin
      sel = $urandom_range(0, 99);
      b = (sel < 80) ? 8'($urandom_range(1, 131)) : 8'($urandom);
      if (n % 300 == 150) quiet_sink = ~quiet_sink;
      if (sel < 20) send_item(KIND_POLL, 8'($urandom));
      else if (sel < 30) send_item(KIND_SCAN, 8'($urandom));
      else begin
        if ($urandom_range(0, 3) == 0) send_item(KIND_SCAN, BYTE_EXT);
        if ($urandom_range(0, 2) == 0) send_item(KIND_SCAN, BYTE_REL);
        send_item(KIND_SCAN, b);
      end
    end
    quiet_sink = 1'b0;
    wait_drained();
  endtask

  task automatic test_stall();
    @(posedge clk);
    stall_go = 1'b1;
    for (int n = 0; n < 8; n++) begin
      send_item(KIND_SCAN, 8'($urandom_range(1, 131)), 0);
      send_item(KIND_POLL, 8'h00, 0);
    end
    wait_drained();
  endtask

  initial begin
    scan_in.valid     <= 1'b0;
    scan_in.kind      <= KIND_SCAN;
    scan_in.scan_byte <= 8'h00;
    keys_down = '0;
    ext_pend = 1'b0; rel_pend = 1'b0; changed = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_release_and_overflow();
    test_random_typing();
    test_stall();
    repeat (600) @(posedge clk);
    $display("sent %0d scan/poll transactions, checked %0d reports, %0d mismatches",
             items_sent, reports_seen, mismatches);
    if (mismatches == 0 && reports_due.size() == 0)
      $display("ps2_scan_to_hid_report_tb: PASS");
    else
      $display("ps2_scan_to_hid_report_tb: FAIL");
    $finish;
  end

  initial begin
    #100ms;
    $display("ps2_scan_to_hid_report_tb: FAIL");
    $finish;
  end
endmodule
